FILE: rtl/rational_arithmetic_unit_defines.svh
// ============================================================================
// Assertion macros for the rational arithmetic unit
// Assertions compile in simulation and drop out when SYNTH is defined.
// ============================================================================
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RAU_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rst_n, prop)
`define RAU_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/rau_pkg.sv
// ============================================================================
// rau_pkg
// Shared codes and types of the rational arithmetic unit.
// ============================================================================
`default_nettype none
package rau_pkg;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_RED = 3'd5;

    // Divider request and reply between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/rau_divider.sv
// ============================================================================
// rau_divider
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rau_divider
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  rau_pkg::div_req_t     req,
    output rau_pkg::div_rsp_t     rsp
);
    import rau_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        shifted   = {r_reg[63:0], q_reg[63]};
        diff      = shifted - {1'b0, d_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = req.dividend;
            r_next    = 65'd0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            if (diff[64])
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            else
            begin
                r_next = diff;
                q_next = {q_reg[62:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg[63:0];

    `RAU_ASSERT_NEXT(a_done_after_busy, clk, rst_n, busy_reg && &cnt_reg && !req.start, done_reg)
    `RAU_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done_reg |-> !busy_reg)
    `RAU_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg)
endmodule
`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// ============================================================================
// rational_arithmetic_unit
// Fraction add, subtract, multiply, divide, negate and reduce with GCD.
// ============================================================================
//  channel | direction | handshake           | payload
//  input   | in        | in_valid/in_ready   | operation, a_num, a_den, b_num, b_den
//  output  | out       | out_valid/out_ready | res_num, res_den, ok
//
// Each transaction is worked by a sequencer around one 64-bit divider that
// produces one quotient bit per cycle. Products are formed one 33x33 signed
// multiply per cycle. Euclid's algorithm runs one modulo per step, then two
// divisions reduce the fraction. in_ready is high only when the sequencer is
// idle and the result register is empty.
// Reset clears the control state; the result waits as long as out_ready is low.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic signed [31:0] a_num,
    input  wire logic [31:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic [31:0] b_den,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] res_num,
    output logic [31:0]      res_den,
    output logic             ok
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;  // dispatch; pre-step (negate b or a / reciprocal of b)
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_COMB  = 4'd5;
    localparam logic [3:0] S_RED   = 4'd6;  // reduction entry
    localparam logic [3:0] S_GCD   = 4'd7;
    localparam logic [3:0] S_GWAIT = 4'd8;
    localparam logic [3:0] S_DNUM  = 4'd9;
    localparam logic [3:0] S_WNUM  = 4'd10;
    localparam logic [3:0] S_DDEN  = 4'd11;
    localparam logic [3:0] S_WDEN  = 4'd12;
    localparam logic [3:0] S_FAIL  = 4'd13;
    localparam logic [3:0] S_BRED  = 4'd14; // b was reduced, now continue

    logic [3:0]  state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic signed [32:0] an_reg, an_next;
    logic [31:0] ad_reg, ad_next;
    logic signed [32:0] bn_reg, bn_next;
    logic [31:0] bd_reg, bd_next;
    logic        bpass_reg, bpass_next;  // reducing b as pre-step
    logic signed [64:0] p1_reg, p1_next;
    logic signed [64:0] p2_reg, p2_next;
    logic [63:0] pd_reg, pd_next;
    logic signed [32:0] rn_reg, rn_next;   // fraction under reduction
    logic [31:0] rd_reg, rd_next;
    logic [31:0] gm_reg, gm_next;
    logic [31:0] gn_reg, gn_next;
    logic        neg_reg, neg_next;
    logic [31:0] qn_reg, qn_next;
    logic        ov_reg, ov_next;
    logic signed [31:0] on_reg, on_next;
    logic [31:0] od_reg, od_next;
    logic        ook_reg, ook_next;
    div_req_t    dreq;
    div_rsp_t    drsp;

    // Shared 33x33 signed multiplier operands.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] sum;
    logic [32:0] mag;

    assign mul_p = mul_a * mul_b;
    assign sum   = {p1_reg[64], p1_reg} + {p2_reg[64], p2_reg};
    assign mag   = rn_reg[32] ? 33'(-rn_reg) : 33'(rn_reg);

    rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign res_num   = on_reg;
    assign res_den   = od_reg;
    assign ok        = ook_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; an_next = an_reg; ad_next = ad_reg;
        bn_next = bn_reg; bd_next = bd_reg; bpass_next = bpass_reg;
        p1_next = p1_reg; p2_next = p2_reg; pd_next = pd_reg;
        rn_next = rn_reg; rd_next = rd_reg; gm_next = gm_reg; gn_next = gn_reg;
        neg_next = neg_reg; qn_next = qn_reg;
        ov_next = ov_reg; on_next = on_reg; od_next = od_reg; ook_next = ook_reg;
        dreq.start = 1'b0; dreq.dividend = 64'd0; dreq.divisor = 64'd1;
        mul_a = an_reg; mul_b = 33'(signed'({1'b0, bd_reg}));
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next = operation;
                    an_next = 33'(a_num); ad_next = a_den;
                    bn_next = 33'(b_num); bd_next = b_den;
                    bpass_next = 1'b0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                case (op_reg)
                    OP_ADD, OP_MUL: state_next = S_M1;
                    OP_SUB:
                    begin
                        if (bn_reg == -33'sd2147483648) state_next = S_FAIL;
                        else
                        begin
                            rn_next = -bn_reg; rd_next = bd_reg;
                            bpass_next = 1'b1; state_next = S_RED;
                        end
                    end
                    OP_DIV:
                    begin
                        if (bn_reg == 33'sd0 || bd_reg[31]) state_next = S_FAIL;
                        else
                        begin
                            rn_next = bn_reg[32] ? -33'(signed'({1'b0, bd_reg}))
                                                 : 33'(signed'({1'b0, bd_reg}));
                            rd_next = 32'(bn_reg[32] ? -bn_reg : bn_reg);
                            bpass_next = 1'b1; state_next = S_RED;
                        end
                    end
                    OP_NEG:
                    begin
                        if (an_reg == -33'sd2147483648) state_next = S_FAIL;
                        else
                        begin
                            rn_next = -an_reg; rd_next = ad_reg; state_next = S_RED;
                        end
                    end
                    OP_RED:
                    begin
                        rn_next = an_reg; rd_next = ad_reg; state_next = S_RED;
                    end
                    default: state_next = S_FAIL;
                endcase
            end
            S_BRED:
            begin
                bn_next = 33'(on_reg); bd_next = od_reg;
                bpass_next = 1'b0;
                state_next = S_M1;
            end
            S_M1:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_ADD || op_reg == OP_SUB)
                        ? 33'(signed'({1'b0, bd_reg})) : bn_reg;
                p1_next = 65'(mul_p);
                state_next = S_M2;
            end
            S_M2:
            begin
                mul_a = bn_reg;
                mul_b = 33'(signed'({1'b0, ad_reg}));
                p2_next = 65'(mul_p);
                state_next = S_M3;
            end
            S_M3:
            begin
                mul_a = 33'(signed'({1'b0, ad_reg}));
                mul_b = 33'(signed'({1'b0, bd_reg}));
                pd_next = 64'(mul_p);
                state_next = S_COMB;
            end
            S_COMB:
            begin
                if (op_reg == OP_MUL || op_reg == OP_DIV)
                    p2_next = 65'sd0;
                state_next = S_RED;
                // Range checks happen below on the numerator product or sum and on the denominator product.
                if (op_reg == OP_MUL || op_reg == OP_DIV)
                begin
                    if (p1_reg > 65'sd2147483647 || p1_reg < -65'sd2147483648
                        || pd_reg[63:32] != 32'd0)
                        state_next = S_FAIL;
                    else
                    begin
                        rn_next = 33'(p1_reg); rd_next = pd_reg[31:0];
                    end
                end
                else
                begin
                    if (sum > 66'sd2147483647 || sum < -66'sd2147483648
                        || pd_reg[63:32] != 32'd0)
                        state_next = S_FAIL;
                    else
                    begin
                        rn_next = 33'(sum); rd_next = pd_reg[31:0];
                    end
                end
            end
            S_RED:
            begin
                if (rd_reg == 32'd0)
                    state_next = S_FAIL;
                else
                begin
                    gm_next = mag[31:0]; gn_next = rd_reg;
                    neg_next = rn_reg[32];
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gn_reg == 32'd0)
                    state_next = S_DNUM;
                else
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = {32'd0, gm_reg};
                    dreq.divisor = {32'd0, gn_reg};
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (drsp.done)
                begin
                    gm_next = gn_reg; gn_next = drsp.rem[31:0];
                    state_next = S_GCD;
                end
            end
            S_DNUM:
            begin
                dreq.start = 1'b1;
                dreq.dividend = {31'd0, mag};
                dreq.divisor = {32'd0, gm_reg};
                state_next = S_WNUM;
            end
            S_WNUM:
            begin
                if (drsp.done)
                begin
                    qn_next = drsp.quot[31:0];
                    state_next = S_DDEN;
                end
            end
            S_DDEN:
            begin
                dreq.start = 1'b1;
                dreq.dividend = {32'd0, rd_reg};
                dreq.divisor = {32'd0, gm_reg};
                state_next = S_WDEN;
            end
            S_WDEN:
            begin
                if (drsp.done)
                begin
                    on_next = neg_reg ? -signed'(qn_reg) : signed'(qn_reg);
                    od_next = drsp.quot[31:0];
                    if (bpass_reg)
                        state_next = S_BRED;
                    else
                    begin
                        ook_next = 1'b1; ov_next = 1'b1; state_next = S_IDLE;
                    end
                end
            end
            S_FAIL:
            begin
                on_next = 32'sd0; od_next = 32'd0; ook_next = 1'b0;
                ov_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; an_reg <= an_next; ad_reg <= ad_next;
        bn_reg <= bn_next; bd_reg <= bd_next; bpass_reg <= bpass_next;
        p1_reg <= p1_next; p2_reg <= p2_next; pd_reg <= pd_next;
        rn_reg <= rn_next; rd_reg <= rd_next; gm_reg <= gm_next; gn_reg <= gn_next;
        neg_reg <= neg_next; qn_reg <= qn_next;
        on_reg <= on_next; od_reg <= od_next; ook_reg <= ook_next;
    end

    `RAU_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready |-> state_reg == S_IDLE)
    `RAU_ASSERT_IMPL(a_fail_zero, clk, rst_n, (out_valid && !ok) |-> {res_num, res_den} == 64'd0)
    `RAU_ASSERT_IMPL(a_ok_den, clk, rst_n, (out_valid && ok) |-> res_den != 32'd0)
    `RAU_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_reg == S_PREP)
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ============================================================================
// Rational arithmetic unit testbench
// Drives fraction transactions through the valid/ready input channel and
// checks every returned result against a fraction predictor in this file.
// Both channels idle at random, with one receiver hold-off and one drain.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import rau_pkg::*;

    // Codes the package leaves undefined; the block must fail them.
    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_OFF_CYCLES = 3000;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] an;
        logic [31:0]        ad;
        logic signed [31:0] bn;
        logic [31:0]        bd;
    } frac_req_t;

    typedef struct {
        logic signed [31:0] num;
        logic [31:0]        den;
        logic               ok;
    } frac_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] operation = '0;
    logic signed [31:0] a_num = '0;
    logic [31:0] a_den = '0;
    logic signed [31:0] b_num = '0;
    logic [31:0] b_den = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] res_num;
    logic [31:0] res_den;
    logic ok;

    frac_req_t pending_ops[$];
    frac_res_t expected_fracs[$];
    int mismatches = 0;
    int sent_count = 0;
    int checked_count = 0;
    int ok_count = 0;
    bit drain_request = 1'b0;
    bit calm_phase = 1'b0;
    int hold_off_left = 0;
    bit hold_off_done = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rational_arithmetic_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .a_num(a_num), .a_den(a_den),
        .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_num(res_num), .res_den(res_den), .ok(ok)
    );

    // Lowest terms by Euclid; fails only on a zero denominator.
    function automatic bit lowest_terms(input longint num, input longint unsigned den,
                                        output longint rnum, output longint unsigned rden);
        longint unsigned m;
        longint unsigned n;
        longint unsigned t;
        rnum = 0;
        rden = 0;
        if (den == 0)
            return 1'b0;
        m = (num < 0) ? longint'(-num) : longint'(num);
        n = den;
        while (n != 0)
        begin
            t = m % n;
            m = n;
            n = t;
        end
        rnum = num / longint'(m);
        rden = den / m;
        return 1'b1;
    endfunction

    // Exact sum of two fractions; fails when the result leaves 32 bits.
    function automatic bit frac_sum(input longint an, input longint unsigned ad,
                                    input longint bn, input longint unsigned bd,
                                    output longint rnum, output longint unsigned rden);
        longint p1;
        longint p2;
        logic signed [65:0] s;
        longint unsigned d;
        p1 = an * longint'(bd);
        p2 = bn * longint'(ad);
        s = p1;
        s = s + p2;
        d = ad * bd;
        rnum = 0;
        rden = 0;
        if (s < -66'sd2147483648 || s > 66'sd2147483647 || d > 64'hFFFF_FFFF)
            return 1'b0;
        return lowest_terms(longint'(s), d, rnum, rden);
    endfunction

    function automatic bit frac_product(input longint an, input longint unsigned ad,
                                        input longint bn, input longint unsigned bd,
                                        output longint rnum, output longint unsigned rden);
        longint p;
        longint unsigned d;
        p = an * bn;
        d = ad * bd;
        rnum = 0;
        rden = 0;
        if (p < -64'sd2147483648 || p > 64'sd2147483647 || d > 64'hFFFF_FFFF)
            return 1'b0;
        return lowest_terms(p, d, rnum, rden);
    endfunction

    function automatic frac_res_t predict_fraction(input frac_req_t rq);
        frac_res_t r;
        longint an;
        longint bn;
        longint unsigned ad;
        longint unsigned bd;
        longint tn;
        longint unsigned td;
        longint rn;
        longint unsigned rd;
        bit good;
        an = rq.an;
        bn = rq.bn;
        ad = rq.ad;
        bd = rq.bd;
        rn = 0;
        rd = 0;
        good = 1'b0;
        case (rq.op)
            OP_ADD: good = frac_sum(an, ad, bn, bd, rn, rd);
            OP_SUB:
            begin
                // The minimum numerator cannot be negated.
                if (bn != -64'sd2147483648 && lowest_terms(-bn, bd, tn, td))
                    good = frac_sum(an, ad, tn, td, rn, rd);
            end
            OP_MUL: good = frac_product(an, ad, bn, bd, rn, rd);
            OP_DIV:
            begin
                // Reciprocal: zero fails, the sign moves to the numerator, and a
                // denominator too wide for a signed numerator fails.
                if (bn != 0 && bd <= 64'h7FFF_FFFF)
                begin
                    if (bn < 0)
                        good = lowest_terms(-longint'(bd), longint'(-bn), tn, td);
                    else
                        good = lowest_terms(longint'(bd), longint'(bn), tn, td);
                    if (good)
                        good = frac_product(an, ad, tn, td, rn, rd);
                end
            end
            OP_NEG:
            begin
                if (an != -64'sd2147483648)
                    good = lowest_terms(-an, ad, rn, rd);
            end
            OP_RED: good = lowest_terms(an, ad, rn, rd);
            default: good = 1'b0;
        endcase
        if (!good)
        begin
            rn = 0;
            rd = 0;
        end
        r.num = rn[31:0];
        r.den = rd[31:0];
        r.ok = good;
        return r;
    endfunction

    task automatic queue_op(input logic [2:0] op, input logic signed [31:0] an,
                            input logic [31:0] ad, input logic signed [31:0] bn,
                            input logic [31:0] bd);
        frac_req_t rq;
        rq.op = op;
        rq.an = an;
        rq.ad = ad;
        rq.bn = bn;
        rq.bd = bd;
        pending_ops.push_back(rq);
    endtask

    function automatic logic [31:0] pick_value(input int mode);
        case (mode)
            0: return $urandom_range(0, 40);
            1: return $urandom_range(0, 3000);
            2: return $urandom;
            default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_signed(input int mode);
        logic [31:0] v;
        v = pick_value(mode);
        if (mode < 2 && $urandom_range(0, 1) != 0)
            v = -v;
        return v;
    endfunction

    // Driver: a new transaction goes out once the previous one is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                frac_req_t cur;
                cur.op = operation;
                cur.an = a_num;
                cur.ad = a_den;
                cur.bn = b_num;
                cur.bd = b_den;
                expected_fracs.push_back(predict_fraction(cur));
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() == 0 || (drain_request && expected_fracs.size() != 0)
                    || (!calm_phase && $urandom_range(0, 99) < 34))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    frac_req_t nx;
                    nx = pending_ops.pop_front();
                    if (drain_request)
                        drain_request <= 1'b0;
                    in_valid <= 1'b1;
                    operation <= nx.op;
                    a_num <= nx.an;
                    a_den <= nx.ad;
                    b_num <= nx.bn;
                    b_den <= nx.bd;
                end
            end
        end
    end

    // Monitor: checks each result and drives out_ready.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_fracs.size() == 0)
                begin
                    $error("result with no transaction outstanding: %0d/%0d ok=%0b",
                           res_num, res_den, ok);
                    mismatches++;
                end
                else
                begin
                    frac_res_t ex;
                    ex = expected_fracs.pop_front();
                    if (res_num !== ex.num)
                    begin
                        $error("res_num expected %0d actual %0d", ex.num, res_num);
                        mismatches++;
                    end
                    if (res_den !== ex.den)
                    begin
                        $error("res_den expected %0d actual %0d", ex.den, res_den);
                        mismatches++;
                    end
                    if (ok !== ex.ok)
                    begin
                        $error("ok expected %0b actual %0b", ex.ok, ok);
                        mismatches++;
                    end
                    if (ex.ok)
                        ok_count++;
                end
                checked_count++;
            end
            // One long hold-off while the sender keeps offering transactions.
            if (!hold_off_done && checked_count == 200)
            begin
                hold_off_done <= 1'b1;
                hold_off_left <= HOLD_OFF_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_off_left > 0)
            begin
                hold_off_left <= hold_off_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm_phase || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    initial
    begin
        int mode;
        int pick;
        logic [2:0] op;
        // Directed part: extremes, every code and each special case.
        queue_op(OP_ADD, 1, 2, 1, 3);
        queue_op(OP_ADD, 32'h7FFF_FFFF, 1, 1, 1);
        queue_op(OP_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
        queue_op(OP_ADD, 1, 32'hFFFF_FFFF, 1, 2);
        queue_op(OP_ADD, 5, 0, 1, 1);
        queue_op(OP_SUB, 3, 4, 1, 4);
        queue_op(OP_SUB, 1, 1, 32'h8000_0000, 1);
        queue_op(OP_SUB, 1, 1, 2, 0);
        queue_op(OP_MUL, 6, 4, -2, 9);
        queue_op(OP_MUL, 32'h8000_0000, 1, -1, 1);
        queue_op(OP_MUL, 65536, 3, 65536, 5);
        queue_op(OP_DIV, 2, 3, 4, 5);
        queue_op(OP_DIV, 2, 3, 0, 5);
        queue_op(OP_DIV, 2, 3, -4, 6);
        queue_op(OP_DIV, 2, 3, 1, 32'h8000_0000);
        queue_op(OP_DIV, 7, 9, 3, 0);
        queue_op(OP_NEG, 32'h8000_0000, 5, 0, 0);
        queue_op(OP_NEG, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_RED, 12, 18, 0, 0);
        queue_op(OP_RED, 0, 7, 0, 0);
        queue_op(OP_RED, -12, 0, 0, 0);
        queue_op(OP_RED, 32'h8000_0000, 32'h8000_0000, 0, 0);
        queue_op(OP_UNDEF_6, 1, 1, 1, 1);
        queue_op(OP_UNDEF_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Random part: mostly small operands so Euclid stays short.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            mode = (pick < 55) ? 0 : (pick < 80) ? 1 : (pick < 95) ? 2 : 3;
            op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            queue_op(op, pick_signed(mode), pick_value(mode), pick_signed(mode),
                     pick_value(mode));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // A stretch without any idling, then one full drain.
        wait (pending_ops.size() < RANDOM_ITEMS - 300);
        calm_phase = 1'b1;
        wait (pending_ops.size() < RANDOM_ITEMS - 450);
        calm_phase = 1'b0;
        wait (pending_ops.size() < RANDOM_ITEMS - 700);
        drain_request = 1'b1;

        wait (pending_ops.size() == 0 && !in_valid);
        wait (expected_fracs.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d transactions over all operation codes; %0d succeeded.",
                 checked_count, ok_count);
        if (mismatches == 0 && expected_fracs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("Timeout with %0d results still outstanding.", expected_fracs.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
